FILE: rtl/core/sphere_collision_pass_defines.svh
`ifndef SPHERE_COLLISION_PASS_DEFINES_SVH
`define SPHERE_COLLISION_PASS_DEFINES_SVH

// same-cycle implication
`define SCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

    localparam int WORD_W   = 240;
    localparam int POS_LSB  = 0;
    localparam int VEL_LSB  = 96;
    localparam int RAD_LSB  = 192;
    localparam int MASS_LSB = 216;
    localparam int OUT_W    = 192;

    typedef logic [5:0] t_op;

    localparam t_op OP_NOP  = 6'd0;
    localparam t_op OP_LDI  = 6'd1;
    localparam t_op OP_LDJ  = 6'd2;
    localparam t_op OP_DIFF = 6'd3;
    localparam t_op OP_MDD  = 6'd4;
    localparam t_op OP_ACC  = 6'd5;
    localparam t_op OP_MRS  = 6'd6;
    localparam t_op OP_SQRT = 6'd7;
    localparam t_op OP_OVL  = 6'd8;
    localparam t_op OP_MDO  = 6'd9;
    localparam t_op OP_DVS  = 6'd10;
    localparam t_op OP_PUSH = 6'd11;
    localparam t_op OP_MVD  = 6'd12;
    localparam t_op OP_DVV  = 6'd13;
    localparam t_op OP_SETV = 6'd14;
    localparam t_op OP_MDN  = 6'd15;
    localparam t_op OP_DVN  = 6'd16;
    localparam t_op OP_SETN = 6'd17;
    localparam t_op OP_MVN  = 6'd18;
    localparam t_op OP_SETW = 6'd19;
    localparam t_op OP_MWJ  = 6'd20;
    localparam t_op OP_DVM  = 6'd21;
    localparam t_op OP_UPDI = 6'd22;
    localparam t_op OP_MWI  = 6'd23;
    localparam t_op OP_UPDJ = 6'd24;
    localparam t_op OP_OUT  = 6'd25;

    localparam logic [1:0] WSEL_IN = 2'd0;
    localparam logic [1:0] WSEL_I  = 2'd1;
    localparam logic [1:0] WSEL_J  = 2'd2;

    typedef struct packed {
        t_op        op;
        logic [1:0] k;
        logic       ram_we;
        logic [1:0] wsel;
    } t_cmd;

    typedef struct packed {
        logic far;
        logic collide;
        logic dot_go;
        logic sqrt_busy;
        logic div_done;
    } t_stat;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/sphere_collision_pass.sv
// Load: one item per cycle while idle; the item with tlast starts the pass.
// Pass per ordered pair: skipped when i equals j, shortest when far, then when apart,
// then when only pushed, longest with impulse (13 divisions on a bit-serial divider
// plus a square root).
// Output: states ERD, ELD and EOUT per item; EOUT holds while i_m_tready is low.
// Reset (synchronous, active low) empties the set; store content stays undefined.
`timescale 1ns / 1ps
`include "sphere_collision_pass_defines.svh"

module sphere_collision_pass
    import scp_pkg::*;
#(
    parameter int MAX_SPHERES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, mass
    input  logic [239:0] i_s_tdata,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // sphere_index, out_pos_x/y/z, out_vel_x/y/z, zero pad
    output logic [199:0] o_m_tdata,
    output logic         o_m_tlast
);

    localparam int IW = $clog2(MAX_SPHERES);

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [IW-1:0]    w_rd_addr, w_wr_addr, w_emit_idx;
    logic [OUT_W-1:0] w_out;

    scp_ctrl #(.MAX_SPHERES(MAX_SPHERES)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_s_tlast (i_s_tlast),
        .o_s_tready(o_s_tready),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tlast (o_m_tlast),
        .o_emit_idx(w_emit_idx),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr),
        .o_wr_addr (w_wr_addr)
    );

    scp_datapath #(.MAX_SPHERES(MAX_SPHERES)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_in_data (i_s_tdata),
        .o_stat    (w_stat),
        .o_out_data(w_out)
    );

    assign o_m_tdata = {4'b0, w_out, 4'(w_emit_idx)};

    `SCP_ASSERT_NOW(a_no_load_while_emit, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_m_tvalid, "item taken during output")
    `SCP_ASSERT_NEXT(a_last_ends_emit, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast, !o_m_tvalid, "output after last")
    `SCP_ASSERT_NEXT(a_last_reopens, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast, o_s_tready, "not ready after set")

endmodule

FILE: rtl/core/scp_ram.sv
`timescale 1ns / 1ps

module scp_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/scp_div.sv
`timescale 1ns / 1ps

module scp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic [27:0]        i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quot
);

    logic        r_busy, r_done, r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [27:0] r_rem, r_dsr;
    logic [28:0] sh;

    assign sh = {r_rem, r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[63];
            r_q   <= i_dividend[63] ? 64'(-i_dividend) : 64'(i_dividend);
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (sh >= {1'b0, r_dsr}) begin
                r_rem <= 28'(sh - {1'b0, r_dsr});
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= sh[27:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

FILE: rtl/core/scp_datapath.sv
`timescale 1ns / 1ps

module scp_datapath
    import scp_pkg::*;
#(
    parameter int MAX_SPHERES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    input  logic [$clog2(MAX_SPHERES)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_SPHERES)-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]              i_in_data,
    output t_stat                          o_stat,
    output logic [OUT_W-1:0]               o_out_data
);

    logic signed [31:0] r_pi [3];
    logic signed [31:0] r_pj [3];
    logic signed [31:0] r_vi [3];
    logic signed [31:0] r_vj [3];
    logic [23:0]        r_ri, r_rj, r_mi, r_mj;
    logic signed [25:0] r_d [3];
    logic               r_far;
    logic [24:0]        r_rs;
    logic signed [61:0] r_acc;
    logic signed [67:0] r_prod;
    logic [51:0]        r_sx, r_sbit;
    logic [52:0]        r_sres;
    logic               r_sbusy;
    logic signed [25:0] r_ovl;
    logic signed [36:0] r_v;
    logic signed [17:0] r_n;
    logic signed [37:0] r_w;
    logic [OUT_W-1:0]   r_out;

    logic [WORD_W-1:0]  rdata, wdata;
    logic signed [39:0] mul_a;
    logic signed [27:0] mul_b;
    logic               mul_en;
    logic               div_start, div_done;
    logic signed [63:0] div_dvd, div_quot;
    logic [27:0]        div_dsr;
    logic [24:0]        msum;
    logic [26:0]        sq_root;
    logic signed [32:0] dd [3];
    logic signed [32:0] vrel;
    logic signed [67:0] wround;
    logic [52:0]        strial;

    scp_ram #(.W(WORD_W), .DEPTH(MAX_SPHERES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_we),
        .i_waddr(i_wr_addr),
        .i_wdata(wdata),
        .i_raddr(i_rd_addr),
        .o_rdata(rdata)
    );

    scp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dvd),
        .i_divisor (div_dsr),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    assign msum = 25'(r_mi) + 25'(r_mj);
    assign sq_root = r_sres[26:0];
    assign vrel = 33'(r_vi[i_cmd.k]) - 33'(r_vj[i_cmd.k]);
    assign wround = r_prod + (r_prod[67] ? 68'sd65535 : 68'sd0);
    assign strial = r_sres + 53'(r_sbit);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dd[k] = 33'(r_pi[k]) - 33'(r_pj[k]);
        end
    end

    always_comb begin
        unique case (i_cmd.wsel)
            WSEL_I:  wdata = {r_mi, r_ri, r_vi[2], r_vi[1], r_vi[0],
                              r_pi[2], r_pi[1], r_pi[0]};
            WSEL_J:  wdata = {r_mj, r_rj, r_vj[2], r_vj[1], r_vj[0],
                              r_pj[2], r_pj[1], r_pj[0]};
            default: wdata = i_in_data;
        endcase
    end

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_MDD: begin
                mul_a = 40'(r_d[i_cmd.k]);
                mul_b = 28'(r_d[i_cmd.k]);
            end
            OP_MRS: begin
                mul_a = 40'(r_rs);
                mul_b = 28'(r_rs);
            end
            OP_MDO: begin
                mul_a = 40'(r_d[i_cmd.k]);
                mul_b = 28'(r_ovl);
            end
            OP_MVD: begin
                mul_a = 40'(vrel);
                mul_b = 28'(r_d[i_cmd.k]);
            end
            OP_MDN: begin
                mul_a = 40'(r_d[i_cmd.k]);
                mul_b = 28'sd65536;
            end
            OP_MVN: begin
                mul_a = 40'(r_v);
                mul_b = 28'(r_n);
            end
            OP_MWJ: begin
                mul_a = 40'(r_w) <<< 1;
                mul_b = 28'(r_mj);
            end
            OP_MWI: begin
                mul_a = 40'(r_w) <<< 1;
                mul_b = 28'(r_mi);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_comb begin
        div_start = 1'b1;
        div_dvd   = r_prod[63:0];
        div_dsr   = 28'(sq_root);
        unique case (i_cmd.op)
            OP_DVS:  div_dsr = {sq_root, 1'b0};
            OP_DVV:  div_dvd = 64'(r_acc);
            OP_DVN:  div_dsr = 28'(sq_root);
            OP_DVM:  div_dsr = 28'(msum);
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
        end else if (i_cmd.op == OP_SQRT) begin
            r_sbusy <= 1'b1;
        end else if (r_sbusy && r_sbit[0]) begin
            r_sbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SQRT) begin
            r_sx   <= r_acc[51:0];
            r_sres <= '0;
            r_sbit <= 52'd1 << 50;
        end else if (r_sbusy) begin
            if (53'(r_sx) >= strial) begin
                r_sx   <= r_sx - strial[51:0];
                r_sres <= (r_sres >> 1) + 53'(r_sbit);
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_cmd.op)
            OP_LDI: begin
                for (int k = 0; k < 3; k++) begin
                    r_pi[k] <= rdata[POS_LSB + 32*k +: 32];
                    r_vi[k] <= rdata[VEL_LSB + 32*k +: 32];
                end
                r_ri <= rdata[RAD_LSB +: 24];
                r_mi <= rdata[MASS_LSB +: 24];
            end
            OP_LDJ: begin
                for (int k = 0; k < 3; k++) begin
                    r_pj[k] <= rdata[POS_LSB + 32*k +: 32];
                    r_vj[k] <= rdata[VEL_LSB + 32*k +: 32];
                end
                r_rj <= rdata[RAD_LSB +: 24];
                r_mj <= rdata[MASS_LSB +: 24];
            end
            OP_DIFF: begin
                r_far <= 1'b0;
                for (int k = 0; k < 3; k++) begin
                    r_d[k] <= dd[k][25:0];
                    if (dd[k] >= 33'sd33554432 || dd[k] <= -33'sd33554432) begin
                        r_far <= 1'b1;
                    end
                end
                r_rs  <= 25'(r_ri) + 25'(r_rj);
                r_acc <= '0;
            end
            OP_ACC:  r_acc <= r_acc + r_prod[61:0];
            OP_OVL: begin
                r_ovl <= 26'(r_rs) - 26'(sq_root);
                r_acc <= '0;
            end
            OP_PUSH: begin
                r_pi[i_cmd.k] <= sat32(66'(r_pi[i_cmd.k]) + 66'(div_quot));
                r_pj[i_cmd.k] <= sat32(66'(r_pj[i_cmd.k]) - 66'(div_quot));
            end
            OP_SETV: r_v <= div_quot[36:0];
            OP_SETN: r_n <= div_quot[17:0];
            OP_SETW: r_w <= wround[53:16];
            OP_UPDI: r_vi[i_cmd.k] <= sat32(66'(r_vi[i_cmd.k]) - 66'(div_quot));
            OP_UPDJ: r_vj[i_cmd.k] <= sat32(66'(r_vj[i_cmd.k]) + 66'(div_quot));
            OP_OUT:  r_out <= rdata[OUT_W-1:0];
            default: ;
        endcase
    end

    assign o_stat.far       = r_far;
    assign o_stat.collide   = (r_acc != '0) && (68'(r_acc) < r_prod);
    assign o_stat.dot_go    = r_acc[61] && (msum != '0);
    assign o_stat.sqrt_busy = r_sbusy;
    assign o_stat.div_done  = div_done;
    assign o_out_data       = r_out;

endmodule

FILE: rtl/core/scp_ctrl.sv
`timescale 1ns / 1ps

module scp_ctrl
    import scp_pkg::*;
#(
    parameter int MAX_SPHERES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tlast,
    output logic                           o_s_tready,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic                           o_m_tlast,
    output logic [$clog2(MAX_SPHERES)-1:0] o_emit_idx,
    input  t_stat                          i_stat,
    output t_cmd                           o_cmd,
    output logic [$clog2(MAX_SPHERES)-1:0] o_rd_addr,
    output logic [$clog2(MAX_SPHERES)-1:0] o_wr_addr
);

    localparam int IW = $clog2(MAX_SPHERES);
    localparam int CW = $clog2(MAX_SPHERES + 1);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_PAIR = 6'd1;
    localparam logic [5:0] S_RDI  = 6'd2;
    localparam logic [5:0] S_RDJ  = 6'd3;
    localparam logic [5:0] S_LDJ  = 6'd4;
    localparam logic [5:0] S_DIFF = 6'd5;
    localparam logic [5:0] S_SQM  = 6'd6;
    localparam logic [5:0] S_SQA  = 6'd7;
    localparam logic [5:0] S_MRS  = 6'd8;
    localparam logic [5:0] S_CHK  = 6'd9;
    localparam logic [5:0] S_SQW  = 6'd10;
    localparam logic [5:0] S_OVL  = 6'd11;
    localparam logic [5:0] S_PM   = 6'd12;
    localparam logic [5:0] S_PD   = 6'd13;
    localparam logic [5:0] S_PW   = 6'd14;
    localparam logic [5:0] S_DM   = 6'd15;
    localparam logic [5:0] S_DA   = 6'd16;
    localparam logic [5:0] S_DCHK = 6'd17;
    localparam logic [5:0] S_VD   = 6'd18;
    localparam logic [5:0] S_VW   = 6'd19;
    localparam logic [5:0] S_NM   = 6'd20;
    localparam logic [5:0] S_ND   = 6'd21;
    localparam logic [5:0] S_NW   = 6'd22;
    localparam logic [5:0] S_WM   = 6'd23;
    localparam logic [5:0] S_WS   = 6'd24;
    localparam logic [5:0] S_IM   = 6'd25;
    localparam logic [5:0] S_ID   = 6'd26;
    localparam logic [5:0] S_IW   = 6'd27;
    localparam logic [5:0] S_JM   = 6'd28;
    localparam logic [5:0] S_JD   = 6'd29;
    localparam logic [5:0] S_JW   = 6'd30;
    localparam logic [5:0] S_WBI  = 6'd31;
    localparam logic [5:0] S_WBJ  = 6'd32;
    localparam logic [5:0] S_NEXT = 6'd33;
    localparam logic [5:0] S_ERD  = 6'd34;
    localparam logic [5:0] S_ELD  = 6'd35;
    localparam logic [5:0] S_EOUT = 6'd36;

    logic [5:0]    r_state, n_state;
    logic [IW-1:0] r_i, n_i, r_j, n_j, r_e, n_e;
    logic [1:0]    r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_oval, n_oval;
    logic          last_i, last_j, last_e;

    assign last_i = CW'(r_i) == r_cnt - CW'(1);
    assign last_j = CW'(r_j) == r_cnt - CW'(1);
    assign last_e = CW'(r_e) == r_cnt - CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_e <= n_e;
        r_k <= n_k;
    end

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_e       = r_e;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_oval    = r_oval;
        o_cmd     = '{op: OP_NOP, k: r_k, ram_we: 1'b0, wsel: WSEL_IN};
        o_rd_addr = r_i;
        o_wr_addr = r_cnt[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (r_cnt < CW'(MAX_SPHERES)) begin
                        o_cmd.ram_we = 1'b1;
                        n_cnt        = r_cnt + CW'(1);
                    end
                    if (i_s_tlast) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_PAIR;
                    end
                end
            end
            S_PAIR: n_state = (r_i == r_j) ? S_NEXT : S_RDI;
            S_RDI:  n_state = S_RDJ;
            S_RDJ: begin
                o_cmd.op  = OP_LDI;
                o_rd_addr = r_j;
                n_state   = S_LDJ;
            end
            S_LDJ: begin
                o_cmd.op = OP_LDJ;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_k      = '0;
                n_state  = S_SQM;
            end
            S_SQM: begin
                if (i_stat.far) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.op = OP_MDD;
                    n_state  = S_SQA;
                end
            end
            S_SQA: begin
                o_cmd.op = OP_ACC;
                if (r_k == 2'd2) begin
                    n_state = S_MRS;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SQM;
                end
            end
            S_MRS: begin
                o_cmd.op = OP_MRS;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_stat.collide) begin
                    o_cmd.op = OP_SQRT;
                    n_state  = S_SQW;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_SQW: if (!i_stat.sqrt_busy) n_state = S_OVL;
            S_OVL: begin
                o_cmd.op = OP_OVL;
                n_k      = '0;
                n_state  = S_PM;
            end
            S_PM: begin
                o_cmd.op = OP_MDO;
                n_state  = S_PD;
            end
            S_PD: begin
                o_cmd.op = OP_DVS;
                n_state  = S_PW;
            end
            S_PW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_PUSH;
                    if (r_k == 2'd2) begin
                        n_k     = '0;
                        n_state = S_DM;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_PM;
                    end
                end
            end
            S_DM: begin
                o_cmd.op = OP_MVD;
                n_state  = S_DA;
            end
            S_DA: begin
                o_cmd.op = OP_ACC;
                if (r_k == 2'd2) begin
                    n_state = S_DCHK;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_DM;
                end
            end
            S_DCHK: n_state = i_stat.dot_go ? S_VD : S_WBI;
            S_VD: begin
                o_cmd.op = OP_DVV;
                n_state  = S_VW;
            end
            S_VW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_SETV;
                    n_k      = '0;
                    n_state  = S_NM;
                end
            end
            S_NM: begin
                o_cmd.op = OP_MDN;
                n_state  = S_ND;
            end
            S_ND: begin
                o_cmd.op = OP_DVN;
                n_state  = S_NW;
            end
            S_NW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_SETN;
                    n_state  = S_WM;
                end
            end
            S_WM: begin
                o_cmd.op = OP_MVN;
                n_state  = S_WS;
            end
            S_WS: begin
                o_cmd.op = OP_SETW;
                n_state  = S_IM;
            end
            S_IM: begin
                o_cmd.op = OP_MWJ;
                n_state  = S_ID;
            end
            S_ID: begin
                o_cmd.op = OP_DVM;
                n_state  = S_IW;
            end
            S_IW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_UPDI;
                    n_state  = S_JM;
                end
            end
            S_JM: begin
                o_cmd.op = OP_MWI;
                n_state  = S_JD;
            end
            S_JD: begin
                o_cmd.op = OP_DVM;
                n_state  = S_JW;
            end
            S_JW: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_UPDJ;
                    if (r_k == 2'd2) begin
                        n_state = S_WBI;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = S_NM;
                    end
                end
            end
            S_WBI: begin
                o_cmd.ram_we = 1'b1;
                o_cmd.wsel   = WSEL_I;
                o_wr_addr    = r_i;
                n_state      = S_WBJ;
            end
            S_WBJ: begin
                o_cmd.ram_we = 1'b1;
                o_cmd.wsel   = WSEL_J;
                o_wr_addr    = r_j;
                n_state      = S_NEXT;
            end
            S_NEXT: begin
                if (last_j) begin
                    n_j = '0;
                    if (last_i) begin
                        n_e     = '0;
                        n_state = S_ERD;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = S_PAIR;
                    end
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_PAIR;
                end
            end
            S_ERD: begin
                o_rd_addr = r_e;
                n_state   = S_ELD;
            end
            S_ELD: begin
                o_cmd.op = OP_OUT;
                n_oval   = 1'b1;
                n_state  = S_EOUT;
            end
            S_EOUT: begin
                if (i_m_tready) begin
                    n_oval = 1'b0;
                    if (last_e) begin
                        n_cnt   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_e     = r_e + IW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_oval;
    assign o_m_tlast  = last_e;
    assign o_emit_idx = r_e;

endmodule

FILE: test/tb_sphere_collision_pass.sv
`timescale 1ns / 1ps

module tb_sphere_collision_pass;
    import scp_pkg::*;

    localparam int NSPH = 16;
    localparam int WDOG_LIMIT = 1000000;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic [23:0]        r;
        logic [23:0]        m;
        logic               last;
        bit                 drain;
    } t_sphere;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] p [3];
        logic signed [31:0] v [3];
        logic               last;
    } t_state_out;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, radius, mass
    logic [239:0] i_s_tdata;
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // sphere_index, out_pos_x/y/z, out_vel_x/y/z, zero pad
    logic [199:0] o_m_tdata;
    logic         o_m_tlast;

    sphere_collision_pass #(.MAX_SPHERES(NSPH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    t_sphere    pending_spheres [$];
    t_state_out expected_states [$];
    t_sphere    cur_sphere;

    logic signed [31:0] sp_pos [3][NSPH];
    logic signed [31:0] sp_vel [3][NSPH];
    logic [23:0]        sp_rad [NSPH];
    logic [23:0]        sp_mass [NSPH];
    int                 sp_count;

    int  errors;
    int  accepted;
    int  quiet_cycles;
    bit  in_fire;
    bit  out_fire;

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic queue_sphere(input t_sphere s);
        pending_spheres.insert(pending_spheres.size(), s);
    endtask

    task automatic collide_pair(input int i, input int j);
        longint d [3];
        longint w [3];
        longint rs, root, ovl, dot, msum, vv, nk, s, di, dj;
        longint unsigned d2;
        d2 = 0;
        dot = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'(sp_pos[k][i]) - longint'(sp_pos[k][j]);
            if (d[k] >= (64'sd1 <<< 25) || d[k] <= -(64'sd1 <<< 25)) return;
        end
        for (int k = 0; k < 3; k++) d2 += longint'(d[k] * d[k]);
        if (d2 == 0) return;
        rs = longint'(sp_rad[i]) + longint'(sp_rad[j]);
        if (d2 >= longint'(rs * rs)) return;
        root = longint'(int_sqrt(d2));
        ovl = rs - root;
        for (int k = 0; k < 3; k++) begin
            s = (d[k] * ovl) / (2 * root);
            sp_pos[k][i] = clamp32(longint'(sp_pos[k][i]) + s);
            sp_pos[k][j] = clamp32(longint'(sp_pos[k][j]) - s);
        end
        for (int k = 0; k < 3; k++)
            dot += (longint'(sp_vel[k][i]) - longint'(sp_vel[k][j])) * d[k];
        if (dot >= 0) return;
        msum = longint'(sp_mass[i]) + longint'(sp_mass[j]);
        if (msum == 0) return;
        vv = dot / root;
        for (int k = 0; k < 3; k++) begin
            nk = (d[k] * 65536) / root;
            w[k] = (vv * nk) / 65536;
        end
        for (int k = 0; k < 3; k++) begin
            di = (w[k] * 2 * longint'(sp_mass[j])) / msum;
            dj = (w[k] * 2 * longint'(sp_mass[i])) / msum;
            sp_vel[k][i] = clamp32(longint'(sp_vel[k][i]) - di);
            sp_vel[k][j] = clamp32(longint'(sp_vel[k][j]) + dj);
        end
    endtask

    task automatic load_and_resolve(input t_sphere sph);
        t_state_out o;
        if (sp_count < NSPH) begin
            for (int k = 0; k < 3; k++) begin
                sp_pos[k][sp_count] = sph.p[k];
                sp_vel[k][sp_count] = sph.v[k];
            end
            sp_rad[sp_count] = sph.r;
            sp_mass[sp_count] = sph.m;
            sp_count++;
        end
        if (!sph.last) return;
        for (int i = 0; i < sp_count; i++)
            for (int j = 0; j < sp_count; j++)
                if (i != j) collide_pair(i, j);
        for (int i = 0; i < sp_count; i++) begin
            o.idx = i[3:0];
            for (int k = 0; k < 3; k++) begin
                o.p[k] = sp_pos[k][i];
                o.v[k] = sp_vel[k][i];
            end
            o.last = (i == sp_count - 1);
            expected_states.insert(expected_states.size(), o);
        end
        sp_count = 0;
    endtask

    function automatic logic [239:0] pack_sphere(input t_sphere s);
        return {s.m, s.r, s.v[2], s.v[1], s.v[0], s.p[2], s.p[1], s.p[0]};
    endfunction

    function automatic t_sphere mk(input logic signed [31:0] px, input logic signed [31:0] py,
                                   input logic signed [31:0] pz, input logic signed [31:0] vx,
                                   input logic signed [31:0] vy, input logic signed [31:0] vz,
                                   input logic [23:0] r, input logic [23:0] m,
                                   input logic last);
        t_sphere s;
        s.p[0] = px; s.p[1] = py; s.p[2] = pz;
        s.v[0] = vx; s.v[1] = vy; s.v[2] = vz;
        s.r = r; s.m = m; s.last = last; s.drain = 0;
        return s;
    endfunction

    function automatic t_sphere wide_sphere(input logic last);
        logic [23:0] m;
        m = 24'($urandom);
        if (m == 0) m = 24'd1;
        return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  24'($urandom), m, last);
    endfunction

    task automatic add_cluster(input int n);
        logic signed [31:0] c [3];
        logic signed [31:0] vel [3];
        int spread, vmax;
        logic [23:0] m;
        t_sphere s;
        for (int k = 0; k < 3; k++) c[k] = $urandom_range(32'h7000_0000) - 32'sh3800_0000;
        spread = $urandom_range(32'h0002_0000, 32'h0000_4000);
        vmax = ($urandom_range(9) == 0) ? 32'h7fff_ffff : 32'h0004_0000;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++) vel[k] = $urandom_range(vmax) - vmax / 2;
            m = 24'($urandom_range(24'hffffff, 1));
            s = mk(c[0] + $urandom_range(spread) - spread / 2,
                   c[1] + $urandom_range(spread) - spread / 2,
                   c[2] + $urandom_range(spread) - spread / 2,
                   vel[0], vel[1], vel[2],
                   24'($urandom_range(24'h02_0000, 24'h00_8000)), m, i == n - 1);
            queue_sphere(s);
        end
    endtask

    // idle percentages per phase
    function automatic int send_idle_pct();
        case ((accepted / 37) % 4)
            1: return 59;
            3: return 34;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case ((accepted / 37) % 4)
            2: return 59;
            3: return 34;
            default: return 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_s_tvalid && o_s_tready;
        out_fire = i_rst_n && o_m_tvalid && i_m_tready;
        if (in_fire) begin
            load_and_resolve(cur_sphere);
            accepted++;
        end
        if (out_fire) begin
            t_state_out got;
            t_state_out want;
            got.idx = o_m_tdata[3:0];
            got.p[0] = o_m_tdata[35:4];
            got.p[1] = o_m_tdata[67:36];
            got.p[2] = o_m_tdata[99:68];
            got.v[0] = o_m_tdata[131:100];
            got.v[1] = o_m_tdata[163:132];
            got.v[2] = o_m_tdata[195:164];
            got.last = o_m_tlast;
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected item exp none got idx=%0d", $time, got.idx);
                errors++;
            end else begin
                want = expected_states.pop_front();
                if (got.idx !== want.idx) begin
                    $display("%0t: sphere_index exp %0d got %0d", $time, want.idx, got.idx);
                    errors++;
                end
                for (int k = 0; k < 3; k++) begin
                    if (got.p[k] !== want.p[k]) begin
                        $display("%0t: pos[%0d] idx %0d exp %h got %h",
                                 $time, k, want.idx, want.p[k], got.p[k]);
                        errors++;
                    end
                    if (got.v[k] !== want.v[k]) begin
                        $display("%0t: vel[%0d] idx %0d exp %h got %h",
                                 $time, k, want.idx, want.v[k], got.v[k]);
                        errors++;
                    end
                end
                if (got.last !== want.last) begin
                    $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                    errors++;
                end
            end
        end
        if (i_rst_n) begin
            if (in_fire || out_fire) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("tb_sphere_collision_pass failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct());
            if (!i_s_tvalid || in_fire) begin
                if (pending_spheres.size() > 0
                    && !(pending_spheres[0].drain && expected_states.size() > 0)
                    && $urandom_range(99) >= send_idle_pct()) begin
                    cur_sphere = pending_spheres.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= pack_sphere(cur_sphere);
                    i_s_tlast <= cur_sphere.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    initial begin
        int r;
        errors = 0;
        accepted = 0;
        quiet_cycles = 0;
        sp_count = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;

        // field extremes, far apart
        queue_sphere(mk(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 24'hffffff, 0));
        queue_sphere(mk(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 24'h0, 24'h1, 1));
        // coincident centres
        queue_sphere(mk(32'sh10000, 0, 0, 32'sh10000, 0, 0, 24'h20000, 24'h100, 0));
        queue_sphere(mk(32'sh10000, 0, 0, -32'sh10000, 0, 0, 24'h20000, 24'h100, 1));
        // head-on, approaching
        queue_sphere(mk(0, 0, 0, 32'sh10000, 0, 0, 24'h10000, 24'h100, 0));
        queue_sphere(mk(32'sh18000, 0, 0, -32'sh10000, 0, 0, 24'h10000, 24'h300, 1));
        // overlapping, separating
        queue_sphere(mk(0, 32'sh800, 0, -32'sh10000, 0, 0, 24'h10000, 24'h1, 0));
        queue_sphere(mk(32'sh18000, 0, 32'sh400, 32'sh10000, 0, 0, 24'h10000,
                        24'hffffff, 1));
        // single sphere set
        queue_sphere(mk(32'sh1234, 32'sh5678, 32'sh9abc, 1, 2, 3, 24'h1, 24'h1, 1));
        // saturation near the top of the range
        queue_sphere(mk(32'sh7fff8000, 0, 0, 32'sh7fffffff, 0, 0, 24'hff0000,
                        24'h1, 0));
        queue_sphere(mk(32'sh7fff0000, 32'sh100, 0, 32'sh80000000, 0, 0,
                        24'hff0000, 24'hffffff, 1));
        // full set, then a dropped item that starts the pass
        for (int i = 0; i < NSPH; i++) queue_sphere(wide_sphere(0));
        queue_sphere(wide_sphere(1));

        r = 0;
        while (pending_spheres.size() < 310) begin
            int before_n;
            before_n = pending_spheres.size();
            r = $urandom_range(19);
            if (r < 14) begin
                add_cluster(($urandom_range(9) == 0) ? $urandom_range(6, 5)
                                                     : $urandom_range(4, 2));
            end else if (r < 17) begin
                for (int i = $urandom_range(3, 1); i > 0; i--)
                    queue_sphere(wide_sphere(i == 1));
            end else if (r < 19) begin
                queue_sphere(wide_sphere($urandom_range(3) == 0));
            end else begin
                for (int i = 0; i < NSPH + 1; i++)
                    queue_sphere(wide_sphere(i == NSPH));
            end
            if (before_n == 28) pending_spheres[28].drain = 1;
        end
        pending_spheres[pending_spheres.size() - 1].last = 1'b1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        @(posedge i_clk);
        while (pending_spheres.size() > 0 || i_s_tvalid || expected_states.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_states.size() == 0) begin
            $display("tb_sphere_collision_pass passed");
        end else begin
            $display("tb_sphere_collision_pass failed");
        end
        $finish;
    end

endmodule
